// ----- hw/rtl/mer_pkg.sv -----
// Shared types and default sizes for the midpoint ellipse rasterizer.
`default_nettype none

package mer_pkg;

  // Default field sizes.
  localparam int unsigned COORD_BITS_DEF  = 10;
  localparam int unsigned RADIUS_BITS_DEF = 9;

  // Algorithm phase of the ellipse in progress.
  typedef enum logic [1:0] {
    PH_IDLE,
    PH_R1,
    PH_R2,
    PH_DONE
  } phase_t;

  // Controller states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQ_RX,
    ST_SQ_RY,
    ST_PY_INIT,
    ST_DEC_INIT,
    ST_CHECK,
    ST_R2_XX,
    ST_R2_YY,
    ST_R2_A,
    ST_R2_B,
    ST_R2_C,
    ST_R2_DEC,
    ST_EMIT
  } state_t;

  // Datapath operations.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_SQ_RX,
    OP_SQ_RY,
    OP_PY_INIT,
    OP_DEC_INIT,
    OP_R1_STEP,
    OP_R2_STEP,
    OP_XX,
    OP_YY,
    OP_R2_A,
    OP_R2_B,
    OP_R2_C,
    OP_R2_DEC
  } dp_op_t;

  // Command from the controller to the datapath.
  typedef struct packed {
    dp_op_t     op;
    logic       emit;
    logic [1:0] emit_idx;
    logic       done;
  } ctl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic px_lt_py;
    logic y_zero;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

// ----- hw/rtl/mer_ctrl.sv -----
// Controller state machine for the midpoint ellipse rasterizer.
`default_nettype none

module mer_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic                 cmd,
  input  wire mer_pkg::dp_status_t  status,
  output mer_pkg::ctl_cmd_t         ctl
);
  import mer_pkg::*;

  state_t     state, state_next;
  phase_t     phase, phase_next;
  logic [1:0] emit_cnt, emit_cnt_next;
  logic       accept;

  // A new beat is taken only while idle.
  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && (state == ST_IDLE);

  // State, phase and emit counter registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      phase    <= PH_IDLE;
      emit_cnt <= '0;
    end else begin
      state    <= state_next;
      phase    <= phase_next;
      emit_cnt <= emit_cnt_next;
    end
  end

  // Next state, phase and counter.
  always_comb begin
    state_next    = state;
    phase_next    = phase;
    emit_cnt_next = emit_cnt;
    unique case (state)
      ST_IDLE: begin
        emit_cnt_next = '0;
        if (accept) begin
          if (!cmd) begin
            state_next = ST_SQ_RX;
          end else if (phase == PH_R1 || phase == PH_R2) begin
            state_next = ST_CHECK;
          end
        end
      end
      ST_SQ_RX:   state_next = ST_SQ_RY;
      ST_SQ_RY:   state_next = ST_PY_INIT;
      ST_PY_INIT: state_next = ST_DEC_INIT;
      ST_DEC_INIT: begin
        phase_next = PH_R1;
        state_next = ST_CHECK;
      end
      ST_CHECK: begin
        if (phase == PH_R1 && !status.px_lt_py) begin
          state_next = ST_R2_XX;
        end else begin
          if (phase == PH_R2 && status.y_zero) begin
            phase_next = PH_DONE;
          end
          state_next = ST_EMIT;
        end
      end
      ST_R2_XX: state_next = ST_R2_YY;
      ST_R2_YY: state_next = ST_R2_A;
      ST_R2_A:  state_next = ST_R2_B;
      ST_R2_B:  state_next = ST_R2_C;
      ST_R2_C:  state_next = ST_R2_DEC;
      ST_R2_DEC: begin
        phase_next = PH_R2;
        state_next = ST_CHECK;
      end
      ST_EMIT: begin
        if (status.out_free) begin
          emit_cnt_next = emit_cnt + 2'd1;
          if (emit_cnt == 2'd3) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Datapath commands.
  always_comb begin
    ctl          = '0;
    ctl.op       = OP_NONE;
    ctl.emit_idx = emit_cnt;
    ctl.done     = (phase == PH_DONE);
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (!cmd) begin
            ctl.op = OP_LOAD;
          end else if (phase == PH_R1) begin
            ctl.op = OP_R1_STEP;
          end else if (phase == PH_R2) begin
            ctl.op = OP_R2_STEP;
          end
        end
      end
      ST_SQ_RX:    ctl.op = OP_SQ_RX;
      ST_SQ_RY:    ctl.op = OP_SQ_RY;
      ST_PY_INIT:  ctl.op = OP_PY_INIT;
      ST_DEC_INIT: ctl.op = OP_DEC_INIT;
      ST_R2_XX:    ctl.op = OP_XX;
      ST_R2_YY:    ctl.op = OP_YY;
      ST_R2_A:     ctl.op = OP_R2_A;
      ST_R2_B:     ctl.op = OP_R2_B;
      ST_R2_C:     ctl.op = OP_R2_C;
      ST_R2_DEC:   ctl.op = OP_R2_DEC;
      ST_EMIT:     ctl.emit = status.out_free;
      default:     ctl.op = OP_NONE;
    endcase
  end

endmodule

`default_nettype wire

// ----- hw/rtl/mer_datapath.sv -----
// Datapath of the midpoint ellipse rasterizer: terms, shared multiplier, point output.
`default_nettype none

module mer_datapath #(
  parameter int unsigned COORD_BITS  = mer_pkg::COORD_BITS_DEF,
  parameter int unsigned RADIUS_BITS = mer_pkg::RADIUS_BITS_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire mer_pkg::ctl_cmd_t         ctl,
  output mer_pkg::dp_status_t            status,
  input  wire logic [COORD_BITS-1:0]     center_x,
  input  wire logic [COORD_BITS-1:0]     center_y,
  input  wire logic [RADIUS_BITS-1:0]    radius_x,
  input  wire logic [RADIUS_BITS-1:0]    radius_y,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic signed [COORD_BITS+1:0]   pixel_x,
  output logic signed [COORD_BITS+1:0]   pixel_y,
  output logic                           group_last,
  output logic                           ellipse_done
);
  import mer_pkg::*;

  localparam int unsigned RB     = RADIUS_BITS;
  localparam int unsigned OUT_W  = COORD_BITS + 2;
  localparam int unsigned SQ_W   = 2 * RB;
  localparam int unsigned SX_W   = RB + 1;
  localparam int unsigned MA_W   = 2 * RB + 2;
  localparam int unsigned MP_W   = MA_W + SQ_W;
  localparam int unsigned TERM_W = 3 * RB + 4;
  localparam int unsigned DEC_W  = 4 * RB + 7;
  localparam int unsigned SUM_W  = COORD_BITS + RB + 3;

  // Ellipse state.
  logic [COORD_BITS-1:0]    cen_x, cen_y;
  logic [RB-1:0]            rx_in, ry_in;
  logic [SQ_W-1:0]          rx_sq, ry_sq;
  logic [SX_W-1:0]          step_x;
  logic [RB-1:0]            step_y;
  logic signed [TERM_W-1:0] px_term, py_term;
  logic signed [DEC_W-1:0]  decision;

  // Region 2 setup scratch.
  logic [MA_W-1:0]          xx_val;
  logic [SQ_W-1:0]          yy_val;
  logic signed [DEC_W-1:0]  acc;

  // Shared multiplier.
  logic [MA_W-1:0]          mul_a;
  logic [SQ_W-1:0]          mul_b;
  logic [MP_W-1:0]          mul_p;
  logic signed [DEC_W-1:0]  mul_d;
  logic [RB-1:0]            ym1;

  // Sign-extended views and iteration results.
  logic signed [DEC_W-1:0]  rx_sq_d, ry_sq_d, px_next_d, py_next_d;
  logic signed [TERM_W-1:0] rx2_t, ry2_t, px_next, py_next;
  logic signed [DEC_W-1:0]  r1_dec_next, r2_dec_next;
  logic signed [DEC_W-1:0]  dec_src, dec_round;
  logic                     rnd_up;

  // Output point.
  logic [SUM_W-1:0]         sum_x, sum_y;

  assign ym1 = (step_y == '0) ? RB'(1) : (step_y - RB'(1));

  // Operand selection for the one multiplier.
  always_comb begin
    unique case (ctl.op)
      OP_SQ_RX: begin
        mul_a = MA_W'(rx_in);
        mul_b = SQ_W'(rx_in);
      end
      OP_SQ_RY: begin
        mul_a = MA_W'(ry_in);
        mul_b = SQ_W'(ry_in);
      end
      OP_PY_INIT: begin
        mul_a = MA_W'(ry_in);
        mul_b = rx_sq;
      end
      OP_XX: begin
        mul_a = MA_W'(step_x) + MA_W'(1);
        mul_b = SQ_W'(step_x);
      end
      OP_YY: begin
        mul_a = MA_W'(ym1);
        mul_b = SQ_W'(ym1);
      end
      OP_R2_A: begin
        mul_a = xx_val;
        mul_b = ry_sq;
      end
      OP_R2_B: begin
        mul_a = MA_W'(yy_val);
        mul_b = rx_sq;
      end
      OP_R2_C: begin
        mul_a = MA_W'(ry_sq);
        mul_b = rx_sq;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = MP_W'(mul_a) * MP_W'(mul_b);
  assign mul_d = $signed(DEC_W'(mul_p));

  // Common extended terms.
  assign rx_sq_d = $signed(DEC_W'(rx_sq));
  assign ry_sq_d = $signed(DEC_W'(ry_sq));
  assign rx2_t   = $signed(TERM_W'({rx_sq, 1'b0}));
  assign ry2_t   = $signed(TERM_W'({ry_sq, 1'b0}));
  assign px_next = px_term + ry2_t;
  assign py_next = py_term - rx2_t;
  assign px_next_d = DEC_W'(px_next);
  assign py_next_d = DEC_W'(py_next);

  // Decision updates for one iteration of each region.
  always_comb begin
    if (decision[DEC_W-1]) begin
      r1_dec_next = decision + ry_sq_d + px_next_d;
    end else begin
      r1_dec_next = decision + ry_sq_d + px_next_d - py_next_d;
    end
    if (!decision[DEC_W-1] && (decision != '0)) begin
      r2_dec_next = decision + rx_sq_d - py_next_d;
    end else begin
      r2_dec_next = decision + rx_sq_d - py_next_d + px_next_d;
    end
  end

  // Rounding of a quarter-integer: (4v + 2) / 4, truncated toward zero.
  always_comb begin
    if (ctl.op == OP_DEC_INIT) begin
      dec_src = ((ry_sq_d - acc) <<< 2) + rx_sq_d + DEC_W'(2);
    end else begin
      dec_src = (acc <<< 2) + ry_sq_d + DEC_W'(2);
    end
    rnd_up    = dec_src[DEC_W-1] && (dec_src[1:0] != 2'b00);
    dec_round = (dec_src >>> 2) + $signed(DEC_W'(rnd_up));
  end

  // State updates by operation.
  always_ff @(posedge clk) begin
    unique case (ctl.op)
      OP_LOAD: begin
        cen_x   <= center_x;
        cen_y   <= center_y;
        rx_in   <= radius_x;
        ry_in   <= radius_y;
        step_x  <= '0;
        step_y  <= radius_y;
        px_term <= '0;
      end
      OP_SQ_RX: rx_sq <= SQ_W'(mul_p);
      OP_SQ_RY: ry_sq <= SQ_W'(mul_p);
      OP_PY_INIT: acc <= mul_d;
      OP_DEC_INIT: begin
        py_term  <= $signed(TERM_W'({acc, 1'b0}));
        decision <= dec_round;
      end
      OP_R1_STEP: begin
        step_x   <= step_x + SX_W'(1);
        px_term  <= px_next;
        decision <= r1_dec_next;
        if (!decision[DEC_W-1]) begin
          step_y  <= step_y - RB'(1);
          py_term <= py_next;
        end
      end
      OP_R2_STEP: begin
        step_y   <= step_y - RB'(1);
        py_term  <= py_next;
        decision <= r2_dec_next;
        if (decision[DEC_W-1] || (decision == '0)) begin
          step_x  <= step_x + SX_W'(1);
          px_term <= px_next;
        end
      end
      OP_XX:     xx_val   <= MA_W'(mul_p);
      OP_YY:     yy_val   <= SQ_W'(mul_p);
      OP_R2_A:   acc      <= mul_d;
      OP_R2_B:   acc      <= acc + mul_d;
      OP_R2_C:   acc      <= acc - mul_d;
      OP_R2_DEC: decision <= dec_round;
      default: begin
      end
    endcase
  end

  // Point of the current symmetric quadrant.
  always_comb begin
    if (ctl.emit_idx[0]) begin
      sum_x = SUM_W'(cen_x) - SUM_W'(step_x);
    end else begin
      sum_x = SUM_W'(cen_x) + SUM_W'(step_x);
    end
    if (ctl.emit_idx[1]) begin
      sum_y = SUM_W'(cen_y) - SUM_W'(step_y);
    end else begin
      sum_y = SUM_W'(cen_y) + SUM_W'(step_y);
    end
  end

  // Output register: holds a beat until it is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      pixel_x      <= $signed(sum_x[OUT_W-1:0]);
      pixel_y      <= $signed(sum_y[OUT_W-1:0]);
      group_last   <= (ctl.emit_idx == 2'd3);
      ellipse_done <= ctl.done;
    end
  end

  // Status for the controller.
  assign status.px_lt_py = (px_term < py_term);
  assign status.y_zero   = (step_y == '0);
  assign status.out_free = !out_valid || !out_stall;

endmodule

`default_nettype wire

// ----- hw/rtl/midpoint_ellipse_rasterizer.sv -----
// Midpoint ellipse rasterizer, top level: controller plus datapath.
// An advance beat runs one update, one phase check and four point beats.
// A start beat runs a load, four setup steps and a phase check before its point beats; a
// switch to region 2 adds six setup steps, five of them through the one shared multiplier,
// and a second phase check. A new beat is taken only between items. Point beats leave
// through an output register at one per cycle when not stalled. Reset (rst, synchronous)
// returns to idle; advance beats do nothing until a start.
`default_nettype none

module midpoint_ellipse_rasterizer #(
  parameter int unsigned COORD_BITS  = mer_pkg::COORD_BITS_DEF,
  parameter int unsigned RADIUS_BITS = mer_pkg::RADIUS_BITS_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic                      cmd,
  input  wire logic [COORD_BITS-1:0]     center_x,
  input  wire logic [COORD_BITS-1:0]     center_y,
  input  wire logic [RADIUS_BITS-1:0]    radius_x,
  input  wire logic [RADIUS_BITS-1:0]    radius_y,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic signed [COORD_BITS+1:0]   pixel_x,
  output logic signed [COORD_BITS+1:0]   pixel_y,
  output logic                           group_last,
  output logic                           ellipse_done
);
  import mer_pkg::*;

  ctl_cmd_t   ctl;
  dp_status_t status;

  // Sequencer.
  mer_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .status   (status),
    .ctl      (ctl)
  );

  // Arithmetic and output register.
  mer_datapath #(
    .COORD_BITS  (COORD_BITS),
    .RADIUS_BITS (RADIUS_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .ctl          (ctl),
    .status       (status),
    .center_x     (center_x),
    .center_y     (center_y),
    .radius_x     (radius_x),
    .radius_y     (radius_y),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .pixel_x      (pixel_x),
    .pixel_y      (pixel_y),
    .group_last   (group_last),
    .ellipse_done (ellipse_done)
  );

endmodule

`default_nettype wire

// ----- verif/ellipse_check_pkg.sv -----
`timescale 1ns / 100ps
// Scoreboard class that predicts and checks the point stream of the ellipse rasterizer.
package ellipse_check_pkg;
  import mer_pkg::*;

  localparam int unsigned CEN_W       = COORD_BITS_DEF;
  localparam int unsigned RAD_W       = RADIUS_BITS_DEF;
  localparam int unsigned PIX_W       = COORD_BITS_DEF + 2;
  localparam int unsigned MAX_PRINTED = 100;

  // Input command codes.
  localparam logic CMD_START   = 1'b0;
  localparam logic CMD_ADVANCE = 1'b1;

  typedef logic [CEN_W-1:0]        coord_t;
  typedef logic [RAD_W-1:0]        radius_t;
  typedef logic signed [PIX_W-1:0] pix_t;

  typedef struct packed {
    pix_t x;
    pix_t y;
    logic last;
    logic done;
  } point_t;

  class ellipse_tracker;
    point_t          points_due[$];
    int unsigned     mismatches;
    coord_t          cen_x;
    coord_t          cen_y;
    longint          rx_sq;
    longint          ry_sq;
    longint          step_x;
    longint          step_y;
    longint          px_term;
    longint          py_term;
    longint          decision;
    phase_t          phase;

    function new();
      mismatches = 0;
      cen_x      = '0;
      cen_y      = '0;
      rx_sq      = 0;
      ry_sq      = 0;
      step_x     = 0;
      step_y     = 0;
      px_term    = 0;
      py_term    = 0;
      decision   = 0;
      phase      = PH_IDLE;
    endfunction

    function bit walking();
      return (phase == PH_R1) || (phase == PH_R2);
    endfunction

    function int unsigned pending();
      return points_due.size();
    endfunction

    // Move to region 2 once the slope passes -1, and to done once y reaches zero.
    function void next_phase();
      longint xx;
      longint ym1;
      longint base;
      if (phase == PH_R1 && px_term >= py_term) begin
        xx       = step_x * step_x + step_x;
        ym1      = step_y - 1;
        base     = ry_sq * xx + rx_sq * ym1 * ym1 - rx_sq * ry_sq;
        // Rounding of a quarter-integer value, truncated toward zero.
        decision = (4 * base + ry_sq + 2) / 4;
        phase    = PH_R2;
      end
      if (phase == PH_R2 && step_y <= 0) begin
        phase = PH_DONE;
      end
    endfunction

    // Queue the four mirrored points of the current position.
    function void queue_group();
      point_t p;
      longint vx;
      longint vy;
      for (int k = 0; k < 4; k++) begin
        vx     = longint'(cen_x) + ((k % 2 == 0) ? step_x : -step_x);
        vy     = longint'(cen_y) + ((k < 2) ? step_y : -step_y);
        p.x    = vx[PIX_W-1:0];
        p.y    = vy[PIX_W-1:0];
        p.last = (k == 3);
        p.done = (phase == PH_DONE);
        points_due.push_back(p);
      end
    endfunction

    // Note an accepted input beat; returns the number of points it causes.
    function int take_beat(logic c, coord_t cx, coord_t cy, radius_t rx, radius_t ry);
      longint rxv;
      longint ryv;
      if (c == CMD_START) begin
        rxv      = longint'(rx);
        ryv      = longint'(ry);
        cen_x    = cx;
        cen_y    = cy;
        rx_sq    = rxv * rxv;
        ry_sq    = ryv * ryv;
        step_x   = 0;
        step_y   = ryv;
        px_term  = 0;
        py_term  = 2 * rx_sq * ryv;
        decision = (4 * (ry_sq - rx_sq * ryv) + rx_sq + 2) / 4;
        phase    = PH_R1;
      end else if (phase == PH_R1) begin
        step_x  = step_x + 1;
        px_term = px_term + 2 * ry_sq;
        if (decision < 0) begin
          decision = decision + ry_sq + px_term;
        end else begin
          step_y   = step_y - 1;
          py_term  = py_term - 2 * rx_sq;
          decision = decision + ry_sq + px_term - py_term;
        end
      end else if (phase == PH_R2) begin
        step_y  = step_y - 1;
        py_term = py_term - 2 * rx_sq;
        if (decision > 0) begin
          decision = decision + rx_sq - py_term;
        end else begin
          step_x   = step_x + 1;
          px_term  = px_term + 2 * ry_sq;
          decision = decision + rx_sq - py_term + px_term;
        end
      end else begin
        // An advance with no ellipse in progress is ignored.
        return 0;
      end
      next_phase();
      queue_group();
      return 4;
    endfunction

    task report_mismatch(string msg);
      if (mismatches < MAX_PRINTED) begin
        $display("[%0t] mismatch: %s", $time, msg);
      end
      mismatches++;
    endtask

    // Compare one accepted point with the oldest point still due.
    task check_point(pix_t x, pix_t y, logic last, logic done);
      point_t want;
      if (points_due.size() == 0) begin
        report_mismatch($sformatf("unexpected point (%0d,%0d)", x, y));
        return;
      end
      want = points_due.pop_front();
      if (x !== want.x) begin
        report_mismatch($sformatf("pixel_x got %0d want %0d", x, want.x));
      end
      if (y !== want.y) begin
        report_mismatch($sformatf("pixel_y got %0d want %0d", y, want.y));
      end
      if (last !== want.last) begin
        report_mismatch($sformatf("group_last got %b want %b", last, want.last));
      end
      if (done !== want.done) begin
        report_mismatch($sformatf("ellipse_done got %b want %b", done, want.done));
      end
    endtask
  endclass

endpackage

// ----- verif/testbench.sv -----
`timescale 1ns / 100ps
// Top-level testbench that drives and checks the midpoint ellipse rasterizer.
module testbench;
  import mer_pkg::*;
  import ellipse_check_pkg::*;

  localparam int unsigned TOTAL_ITEMS     = 250;
  localparam int unsigned HOLD_OFF_CYCLES = 300;
  localparam int unsigned DRAIN_CYCLES    = 40;
  localparam int unsigned TIMEOUT_NS      = 2_000_000;

  logic    clk       = 1'b0;
  logic    rst       = 1'b1;
  logic    in_valid  = 1'b0;
  logic    in_stall;
  logic    cmd       = CMD_START;
  coord_t  center_x  = '0;
  coord_t  center_y  = '0;
  radius_t radius_x  = '0;
  radius_t radius_y  = '0;
  logic    out_valid;
  logic    out_stall = 1'b0;
  pix_t    pixel_x;
  pix_t    pixel_y;
  logic    group_last;
  logic    ellipse_done;

  ellipse_tracker sb;
  int unsigned    burst_left;
  int unsigned    beat_count;
  bit             in_random_part = 1'b0;

  always #2 clk = ~clk;

  midpoint_ellipse_rasterizer i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .cmd          (cmd),
    .center_x     (center_x),
    .center_y     (center_y),
    .radius_x     (radius_x),
    .radius_y     (radius_y),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .pixel_x      (pixel_x),
    .pixel_y      (pixel_y),
    .group_last   (group_last),
    .ellipse_done (ellipse_done)
  );

  // Offer one input beat, wait for it to be taken, then maybe pause between bursts.
  task automatic send_beat(input logic c, input coord_t cx, input coord_t cy,
                           input radius_t rx, input radius_t ry);
    in_valid <= 1'b1;
    cmd      <= c;
    center_x <= cx;
    center_y <= cy;
    radius_x <= rx;
    radius_y <= ry;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    void'(sb.take_beat(c, cx, cy, rx, ry));
    beat_count++;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(8, 1)) @(posedge clk);
      burst_left = $urandom_range(16, 0);
    end else begin
      burst_left--;
    end
  endtask

  // Start an ellipse, walk it for up to max_adv steps, then send extra advances.
  task automatic run_ellipse(input coord_t cx, input coord_t cy, input radius_t rx,
                             input radius_t ry, input int unsigned max_adv,
                             input int unsigned extra);
    int unsigned n;
    send_beat(CMD_START, cx, cy, rx, ry);
    n = 0;
    while (sb.walking() && n < max_adv) begin
      send_beat(CMD_ADVANCE, coord_t'($urandom), coord_t'($urandom),
                radius_t'($urandom), radius_t'($urandom));
      n++;
    end
    repeat (extra) begin
      send_beat(CMD_ADVANCE, coord_t'($urandom), coord_t'($urandom),
                radius_t'($urandom), radius_t'($urandom));
    end
  endtask

  // Receiver stall pattern: one long hold-off early in the random part, then
  // stretches of no stall, light stall and heavy stall.
  initial begin : rx_stall
    int unsigned mode;
    int unsigned len;
    bit          held_off;
    held_off = 1'b0;
    @(posedge clk);
    forever begin
      if (!held_off && in_random_part) begin
        held_off = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end
      mode = $urandom_range(2);
      len  = $urandom_range(80, 10);
      repeat (len) begin
        case (mode)
          0:       out_stall <= 1'b0;
          1:       out_stall <= ($urandom_range(3) == 0);
          default: out_stall <= ($urandom_range(3) != 0);
        endcase
        @(posedge clk);
      end
    end
  end

  // Check every point beat that the receiver takes.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      sb.check_point(pixel_x, pixel_y, group_last, ellipse_done);
    end
  end

  initial begin : run_limit
    #(TIMEOUT_NS);
    $display("FAIL midpoint_ellipse_rasterizer");
    $finish;
  end

  initial begin : stimulus
    int unsigned kind;
    coord_t      cx;
    coord_t      cy;
    sb          = new();
    beat_count  = 0;
    burst_left  = $urandom_range(6, 0);
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part: advance while idle, zero radii, each zero semi-axis,
    // extreme centers and radii, abandoning an ellipse, advance while done.
    send_beat(CMD_ADVANCE, 10'd1023, 10'd1023, 9'd511, 9'd511);
    run_ellipse(10'd0, 10'd0, 9'd0, 9'd0, 0, 1);
    run_ellipse(10'd1023, 10'd1023, 9'd0, 9'd3, 8, 1);
    run_ellipse(10'd512, 10'd0, 9'd3, 9'd0, 8, 0);
    run_ellipse(10'd1023, 10'd0, 9'd511, 9'd511, 3, 0);
    run_ellipse(10'd0, 10'd1023, 9'd2, 9'd3, 12, 1);

    // Random part: mostly complete small ellipses, some abandoned, some noise.
    in_random_part = 1'b1;
    while (beat_count < TOTAL_ITEMS) begin
      kind = $urandom_range(9);
      cx   = coord_t'($urandom);
      cy   = coord_t'($urandom);
      case (kind)
        0: run_ellipse(cx, cy, radius_t'($urandom), radius_t'($urandom),
                       $urandom_range(6, 1), 0);
        1: send_beat(1'($urandom_range(1)), cx, cy, radius_t'($urandom),
                     radius_t'($urandom));
        2: run_ellipse(cx, cy, radius_t'($urandom_range(20)),
                       radius_t'($urandom_range(20)), $urandom_range(8), 0);
        3: run_ellipse(cx, cy, radius_t'($urandom_range(40)),
                       radius_t'($urandom_range(40)), 1000, $urandom_range(2));
        default: run_ellipse(cx, cy, radius_t'($urandom_range(12)),
                             radius_t'($urandom_range(12)), 1000, $urandom_range(2));
      endcase
    end
    in_valid <= 1'b0;

    // Let the last points drain, then watch for stray ones.
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("PASS midpoint_ellipse_rasterizer");
    end else begin
      $display("FAIL midpoint_ellipse_rasterizer");
    end
    $finish;
  end

endmodule
